// ===== src/ypcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ypcb_pkg: shared types, constants and arithmetic helpers
// Fixed-point constants, the arctangent table and the row codes of the
// camera basis pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ypcb_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int SQRT_CELLS       = 32;
    localparam int DIV_CELLS        = 32;

    localparam logic [24:0] TURN_Q16    = 25'd23592960;
    localparam logic [24:0] HALF_Q16    = 25'd11796480;
    localparam logic [24:0] QUARTER_Q16 = 25'd5898240;
    localparam logic [24:0] THREEQ_Q16  = 25'd17694720;
    localparam logic [22:0] PITCH_LIMIT = 23'd5832704;
    localparam logic [23:0] FOV_MIN     = 24'd327680;
    localparam logic [23:0] FOV_MAX     = 24'd11141120;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [55:0] OFS_ANG     = 56'd5898240;
    localparam logic [55:0] OFS_FOV     = 56'd23592960;
    localparam logic [28:0] DIV180_RECIP = 29'd381774871;
    localparam logic [7:0]  DIV180_VAL  = 8'd180;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;

    localparam logic [2:0] ROW_RIGHT   = 3'd0;
    localparam logic [2:0] ROW_UP      = 3'd1;
    localparam logic [2:0] ROW_FORWARD = 3'd2;
    localparam logic [2:0] ROW_POS     = 3'd3;
    localparam logic [2:0] ROW_FOV     = 3'd4;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        fov_rad;
        logic               fov_apply;
        logic               fold;
    } side_t;

    typedef struct packed {
        logic signed [35:0] fx;
        logic signed [35:0] fy;
        logic signed [35:0] fz;
    } fwd_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } sq_t;

    typedef struct packed {
        logic [31:0] d;
        logic [63:0] rem_x;
        logic [63:0] rem_z;
        logic [31:0] q_x;
        logic [31:0] q_z;
        logic        neg_x;
        logic        neg_z;
        logic        zero;
    } dv_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    // exact floor(v / 180) for v below 2**28
    function automatic logic [20:0] div180(input logic [27:0] v);
        logic [56:0] prod;
        prod = 57'(v) * 57'(DIV180_RECIP);
        return prod[56:36];
    endfunction

    function automatic logic signed [35:0] mulq30(input logic signed [35:0] a,
                                                  input logic signed [35:0] b);
        logic signed [71:0] p;
        p = (72'(a) * 72'(b)) + 72'sd536870912;
        return 36'(p >>> 30);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    function automatic rot_t cordic_step(input rot_t a, input int unsigned s);
        rot_t r;
        logic signed [32:0] at;
        at = 33'(ATAN_Q30[s[4:0]]);
        if (a.z >= 0) begin
            r.x = a.x - (a.y >>> s);
            r.y = a.y + (a.x >>> s);
            r.z = a.z - at;
        end else begin
            r.x = a.x + (a.y >>> s);
            r.y = a.y - (a.x >>> s);
            r.z = a.z + at;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ypcb_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ypcb_cordic_cell: one rotation step for yaw and pitch
// Applies one CORDIC micro-rotation to both angles and hands the pose on.
// ----------------------------------------------------------------------------
`default_nettype none

module ypcb_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 adv,
    input  wire                 in_vld,
    input  ypcb_pkg::rot_t      in_yaw,
    input  ypcb_pkg::rot_t      in_pitch,
    input  ypcb_pkg::side_t     in_side,
    output logic                out_vld,
    output ypcb_pkg::rot_t      out_yaw,
    output ypcb_pkg::rot_t      out_pitch,
    output ypcb_pkg::side_t     out_side
);
    import ypcb_pkg::*;

    logic  vld_reg;
    rot_t  yaw_reg, pitch_reg;
    side_t side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            yaw_reg   <= cordic_step(in_yaw, STEP);
            pitch_reg <= cordic_step(in_pitch, STEP);
            side_reg  <= in_side;
        end
    end

    assign out_vld   = vld_reg;
    assign out_yaw   = yaw_reg;
    assign out_pitch = pitch_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== src/ypcb_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ypcb_sqrt_cell: one result bit of the integer square root
// Tries one bit pair of the radicand and hands remainder and root on.
// ----------------------------------------------------------------------------
`default_nettype none

module ypcb_sqrt_cell #(
    parameter int IDX = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 adv,
    input  wire                 in_vld,
    input  ypcb_pkg::sq_t       in_sq,
    input  ypcb_pkg::fwd_t      in_fwd,
    input  ypcb_pkg::side_t     in_side,
    output logic                out_vld,
    output ypcb_pkg::sq_t       out_sq,
    output ypcb_pkg::fwd_t      out_fwd,
    output ypcb_pkg::side_t     out_side
);
    import ypcb_pkg::*;

    localparam logic [63:0] BIT_VAL = 64'(1) << (62 - 2 * IDX);

    logic        vld_reg;
    sq_t         sq_reg, sq_next;
    fwd_t        fwd_reg;
    side_t       side_reg;
    logic [63:0] trial;

    always_comb begin
        trial = in_sq.res + BIT_VAL;
        if (in_sq.v >= trial) begin
            sq_next.v   = in_sq.v - trial;
            sq_next.res = (in_sq.res >> 1) + BIT_VAL;
        end else begin
            sq_next.v   = in_sq.v;
            sq_next.res = in_sq.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg   <= sq_next;
            fwd_reg  <= in_fwd;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_sq   = sq_reg;
    assign out_fwd  = fwd_reg;
    assign out_side = side_reg;

endmodule

`default_nettype wire

// ===== src/ypcb_div_cell.sv =====
// ----------------------------------------------------------------------------
// ypcb_div_cell: one quotient bit of the two right-vector divisions
// Restoring division step for the x and z numerators over the flat length.
// ----------------------------------------------------------------------------
`default_nettype none

module ypcb_div_cell #(
    parameter int IDX = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 adv,
    input  wire                 in_vld,
    input  ypcb_pkg::dv_t       in_dv,
    input  ypcb_pkg::fwd_t      in_fwd,
    input  ypcb_pkg::side_t     in_side,
    output logic                out_vld,
    output ypcb_pkg::dv_t       out_dv,
    output ypcb_pkg::fwd_t      out_fwd,
    output ypcb_pkg::side_t     out_side
);
    import ypcb_pkg::*;

    localparam int SH = DIV_CELLS - 1 - IDX;

    logic        vld_reg;
    dv_t         dv_reg, dv_next;
    fwd_t        fwd_reg;
    side_t       side_reg;
    logic [63:0] dsh;

    always_comb begin
        dsh     = 64'(in_dv.d) << SH;
        dv_next = in_dv;
        if (in_dv.rem_x >= dsh) begin
            dv_next.rem_x   = in_dv.rem_x - dsh;
            dv_next.q_x[SH] = 1'b1;
        end
        if (in_dv.rem_z >= dsh) begin
            dv_next.rem_z   = in_dv.rem_z - dsh;
            dv_next.q_z[SH] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg   <= dv_next;
            fwd_reg  <= in_fwd;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_dv   = dv_reg;
    assign out_fwd  = fwd_reg;
    assign out_side = side_reg;

endmodule

`default_nettype wire

// ===== src/yaw_pitch_to_camera_basis_top.sv =====
// Rows leave as five row beats per pose; a finished pose waits in the tail until the
// last beat of the previous pose is taken, and every cell chain stalls meanwhile.
// Without such a stall the cell chains take a new pose in every cycle.
// Reset: aresetn (synchronous, active low) clears all valid flags and the row counter.
// ----------------------------------------------------------------------------
// yaw_pitch_to_camera_basis_top: camera basis rows from a yaw/pitch pose
// Angle reduction, CORDIC cell chain, square root and division cell chains,
// cross product, and a five-beat row serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module yaw_pitch_to_camera_basis_top #(
    parameter int CORDIC_STEPS = ypcb_pkg::CORDIC_STEPS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire signed [31:0]   s_yaw_deg,
    input  wire signed [31:0]   s_pitch_deg,
    input  wire signed [31:0]   s_fov_deg,
    input  wire signed [31:0]   s_pos_x,
    input  wire signed [31:0]   s_pos_y,
    input  wire signed [31:0]   s_pos_z,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [2:0]          m_row_index,
    output logic signed [31:0]  m_comp_x,
    output logic signed [31:0]  m_comp_y,
    output logic signed [31:0]  m_comp_z,
    output logic                m_fov_apply,
    output logic                m_last_row
);
    import ypcb_pkg::*;

    logic adv, tail_vld, ser_free;

    // front stages
    logic [8:0]         front_vld_reg;
    logic signed [31:0] yaw0_reg, pitch0_reg, fov0_reg;
    side_t              side_reg [9];

    logic               yneg_reg [1:2];
    logic [31:0]        ymag1_reg;
    logic [7:0]         yq1_reg;
    logic [24:0]        r2_reg, y3_reg;
    logic [22:0]        pm_reg [1:4];
    logic               pneg_reg [1:7];
    logic [23:0]        fc_reg [1:4];
    logic [22:0]        am4_reg;
    logic               aneg_reg [4:7];
    logic [38:0]        np5_reg [3];
    logic [18:0]        nh6_reg [3];
    logic [11:0]        qh6_reg [3];
    logic [11:0]        qh7_reg [3];
    logic [19:0]        nl6_reg [3];
    logic [27:0]        v7_reg [3];
    rot_t               yaw8_reg, pitch8_reg;

    logic [31:0]        ymag_c, pmag_c;
    logic [24:0]        y1_c;
    logic [22:0]        am_c;
    logic               aneg_c, fold_c;
    logic [23:0]        fc_c;
    logic [23:0]        lm_c [3];
    logic [55:0]        prod_c [3];
    logic [31:0]        q_c [3];

    // cell chains
    logic [CORDIC_STEPS:0] cvld;
    rot_t               cyaw [CORDIC_STEPS+1];
    rot_t               cpitch [CORDIC_STEPS+1];
    side_t              cside [CORDIC_STEPS+1];

    logic [SQRT_CELLS:0] sqv;
    sq_t                sqd [SQRT_CELLS+1];
    fwd_t               sqf [SQRT_CELLS+1];
    side_t              sqs [SQRT_CELLS+1];

    logic [DIV_CELLS:0] dvv;
    dv_t                dvd [DIV_CELLS+1];
    fwd_t               dvf [DIV_CELLS+1];
    side_t              dvs [DIV_CELLS+1];

    // post stages
    logic [3:0]         f_vld_reg;
    logic signed [35:0] cy1_reg, sy1_reg, cp1_reg, sp1_reg;
    side_t              fside_reg [4];
    fwd_t               f2_reg, f3_reg, f4_reg;
    logic [63:0]        sqx3_reg, sqz3_reg, sum4_reg;

    logic               d0_vld_reg;
    dv_t                d0_reg;
    fwd_t               d0f_reg;
    side_t              d0s_reg;
    logic [31:0]        flat_c;
    logic [35:0]        afx_c, afz_c;

    logic [2:0]         e_vld_reg;
    side_t              eside_reg [3];
    fwd_t               ef_reg [2];
    logic signed [35:0] rx1_reg, rz1_reg, rx2_reg, rz2_reg;
    logic signed [35:0] m1_reg, m2_reg, m3_reg, m4_reg;
    vec_t               tail_rows_reg [5];
    logic               tail_apply_reg;

    // serializer
    logic               ser_vld_reg;
    logic [2:0]         row_reg;
    vec_t               ser_rows_reg [5];
    logic               ser_apply_reg;
    vec_t               row_c;

    assign tail_vld = e_vld_reg[2];
    assign ser_free = !ser_vld_reg || (m_ready && row_reg == ROW_FOV);
    assign adv      = !tail_vld || ser_free;
    assign s_ready  = adv;

    // ---------------- front control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= '0;
        end else if (adv) begin
            front_vld_reg <= {front_vld_reg[7:0], s_valid};
        end
    end

    always_comb begin
        ymag_c = yaw0_reg[31] ? 32'(-yaw0_reg) : 32'(yaw0_reg);
        pmag_c = pitch0_reg[31] ? 32'(-pitch0_reg) : 32'(pitch0_reg);
        if (fov0_reg <= 32'sd0) begin
            fc_c = '0;
        end else if (fov0_reg < $signed(32'(FOV_MIN))) begin
            fc_c = FOV_MIN;
        end else if (fov0_reg > $signed(32'(FOV_MAX))) begin
            fc_c = FOV_MAX;
        end else begin
            fc_c = fov0_reg[23:0];
        end
        y1_c = (yneg_reg[2] && r2_reg != '0) ? TURN_Q16 - r2_reg : r2_reg;
        if (y3_reg <= QUARTER_Q16) begin
            am_c = y3_reg[22:0];
            aneg_c = 1'b0;
            fold_c = 1'b0;
        end else if (y3_reg < HALF_Q16) begin
            am_c = 23'(HALF_Q16 - y3_reg);
            aneg_c = 1'b1;
            fold_c = 1'b1;
        end else if (y3_reg < THREEQ_Q16) begin
            am_c = 23'(y3_reg - HALF_Q16);
            aneg_c = 1'b0;
            fold_c = 1'b1;
        end else begin
            am_c = 23'(TURN_Q16 - y3_reg);
            aneg_c = 1'b1;
            fold_c = 1'b0;
        end
        lm_c[0] = 24'(am4_reg);
        lm_c[1] = 24'(pm_reg[4]);
        lm_c[2] = fc_reg[4];
        for (int k = 0; k < 3; k++) begin
            prod_c[k] = 56'(lm_c[k]) * 56'(PI_Q30) + ((k == 2) ? OFS_FOV : OFS_ANG);
            q_c[k]    = (32'(qh7_reg[k]) << 20) + 32'(div180(v7_reg[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            yaw0_reg           <= s_yaw_deg;
            pitch0_reg         <= s_pitch_deg;
            fov0_reg           <= s_fov_deg;
            side_reg[0]        <= {s_pos_x, s_pos_y, s_pos_z, 32'd0, 1'b0, 1'b0};

            yneg_reg[1]        <= yaw0_reg[31];
            ymag1_reg          <= ymag_c;
            yq1_reg            <= 8'(div180(28'(ymag_c >> 17)));
            pm_reg[1]          <= (pmag_c > 32'(PITCH_LIMIT)) ? PITCH_LIMIT : pmag_c[22:0];
            pneg_reg[1]        <= pitch0_reg[31];
            fc_reg[1]          <= fc_c;
            side_reg[1]        <= {side_reg[0].pos_x, side_reg[0].pos_y, side_reg[0].pos_z,
                                   side_reg[0].fov_rad, fov0_reg > 32'sd0,
                                   side_reg[0].fold};

            yneg_reg[2]        <= yneg_reg[1];
            r2_reg             <= 25'(ymag1_reg - 32'(yq1_reg) * 32'(TURN_Q16));
            pm_reg[2]          <= pm_reg[1];
            pneg_reg[2]        <= pneg_reg[1];
            fc_reg[2]          <= fc_reg[1];
            side_reg[2]        <= side_reg[1];

            y3_reg             <= y1_c;
            pm_reg[3]          <= pm_reg[2];
            pneg_reg[3]        <= pneg_reg[2];
            fc_reg[3]          <= fc_reg[2];
            side_reg[3]        <= side_reg[2];

            am4_reg            <= am_c;
            aneg_reg[4]        <= aneg_c;
            pm_reg[4]          <= pm_reg[3];
            pneg_reg[4]        <= pneg_reg[3];
            fc_reg[4]          <= fc_reg[3];
            side_reg[4]        <= {side_reg[3].pos_x, side_reg[3].pos_y, side_reg[3].pos_z,
                                   side_reg[3].fov_rad, side_reg[3].fov_apply, fold_c};

            np5_reg[0]         <= 39'(prod_c[0] >> 16);
            np5_reg[1]         <= 39'(prod_c[1] >> 16);
            np5_reg[2]         <= 39'(prod_c[2] >> 18);
            aneg_reg[5]        <= aneg_reg[4];
            pneg_reg[5]        <= pneg_reg[4];
            side_reg[5]        <= side_reg[4];

            for (int k = 0; k < 3; k++) begin
                nh6_reg[k] <= np5_reg[k][38:20];
                nl6_reg[k] <= np5_reg[k][19:0];
                qh6_reg[k] <= 12'(div180(28'(np5_reg[k][38:20])));
                qh7_reg[k] <= qh6_reg[k];
                v7_reg[k]  <= {8'(nh6_reg[k] - 19'(qh6_reg[k]) * 19'(DIV180_VAL)),
                               nl6_reg[k]};
            end
            aneg_reg[6]        <= aneg_reg[5];
            pneg_reg[6]        <= pneg_reg[5];
            side_reg[6]        <= side_reg[5];
            aneg_reg[7]        <= aneg_reg[6];
            pneg_reg[7]        <= pneg_reg[6];
            side_reg[7]        <= side_reg[6];

            yaw8_reg.x         <= CORDIC_GAIN;
            yaw8_reg.y         <= '0;
            yaw8_reg.z         <= aneg_reg[7] ? -$signed(33'(q_c[0])) : $signed(33'(q_c[0]));
            pitch8_reg.x       <= CORDIC_GAIN;
            pitch8_reg.y       <= '0;
            pitch8_reg.z       <= pneg_reg[7] ? -$signed(33'(q_c[1])) : $signed(33'(q_c[1]));
            side_reg[8]        <= {side_reg[7].pos_x, side_reg[7].pos_y, side_reg[7].pos_z,
                                   q_c[2], side_reg[7].fov_apply, side_reg[7].fold};
        end
    end

    // ---------------- CORDIC chain ----------------
    assign cvld[0]   = front_vld_reg[8];
    assign cyaw[0]   = yaw8_reg;
    assign cpitch[0] = pitch8_reg;
    assign cside[0]  = side_reg[8];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        ypcb_cordic_cell #(.STEP(g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_vld    (cvld[g]),
            .in_yaw    (cyaw[g]),
            .in_pitch  (cpitch[g]),
            .in_side   (cside[g]),
            .out_vld   (cvld[g+1]),
            .out_yaw   (cyaw[g+1]),
            .out_pitch (cpitch[g+1]),
            .out_side  (cside[g+1])
        );
    end

    // ---------------- forward vector ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= '0;
        end else if (adv) begin
            f_vld_reg <= {f_vld_reg[2:0], cvld[CORDIC_STEPS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cy1_reg      <= cside[CORDIC_STEPS].fold ? -36'(cyaw[CORDIC_STEPS].x)
                                                     : 36'(cyaw[CORDIC_STEPS].x);
            sy1_reg      <= cside[CORDIC_STEPS].fold ? -36'(cyaw[CORDIC_STEPS].y)
                                                     : 36'(cyaw[CORDIC_STEPS].y);
            cp1_reg      <= 36'(cpitch[CORDIC_STEPS].x);
            sp1_reg      <= 36'(cpitch[CORDIC_STEPS].y);
            fside_reg[0] <= cside[CORDIC_STEPS];

            f2_reg.fx    <= mulq30(sy1_reg, cp1_reg);
            f2_reg.fy    <= sp1_reg;
            f2_reg.fz    <= mulq30(cy1_reg, cp1_reg);
            fside_reg[1] <= fside_reg[0];

            sqx3_reg     <= 64'(f2_reg.fx * f2_reg.fx);
            sqz3_reg     <= 64'(f2_reg.fz * f2_reg.fz);
            f3_reg       <= f2_reg;
            fside_reg[2] <= fside_reg[1];

            sum4_reg     <= sqx3_reg + sqz3_reg;
            f4_reg       <= f3_reg;
            fside_reg[3] <= fside_reg[2];
        end
    end

    // ---------------- square root chain ----------------
    assign sqv[0]     = f_vld_reg[3];
    assign sqd[0].v   = sum4_reg;
    assign sqd[0].res = '0;
    assign sqf[0]     = f4_reg;
    assign sqs[0]     = fside_reg[3];

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        ypcb_sqrt_cell #(.IDX(g)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_vld   (sqv[g]),
            .in_sq    (sqd[g]),
            .in_fwd   (sqf[g]),
            .in_side  (sqs[g]),
            .out_vld  (sqv[g+1]),
            .out_sq   (sqd[g+1]),
            .out_fwd  (sqf[g+1]),
            .out_side (sqs[g+1])
        );
    end

    // ---------------- division setup ----------------
    always_comb begin
        flat_c = sqd[SQRT_CELLS].res[31:0];
        afx_c  = sqf[SQRT_CELLS].fx[35] ? 36'(-sqf[SQRT_CELLS].fx) : 36'(sqf[SQRT_CELLS].fx);
        afz_c  = sqf[SQRT_CELLS].fz[35] ? 36'(-sqf[SQRT_CELLS].fz) : 36'(sqf[SQRT_CELLS].fz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_vld_reg <= 1'b0;
        end else if (adv) begin
            d0_vld_reg <= sqv[SQRT_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d0_reg.d     <= flat_c;
            d0_reg.rem_x <= (64'(afz_c) << 30) + 64'(flat_c >> 1);
            d0_reg.rem_z <= (64'(afx_c) << 30) + 64'(flat_c >> 1);
            d0_reg.q_x   <= '0;
            d0_reg.q_z   <= '0;
            d0_reg.neg_x <= sqf[SQRT_CELLS].fz < 0;
            d0_reg.neg_z <= sqf[SQRT_CELLS].fx > 0;
            d0_reg.zero  <= (flat_c == '0);
            d0f_reg      <= sqf[SQRT_CELLS];
            d0s_reg      <= sqs[SQRT_CELLS];
        end
    end

    // ---------------- division chain ----------------
    assign dvv[0] = d0_vld_reg;
    assign dvd[0] = d0_reg;
    assign dvf[0] = d0f_reg;
    assign dvs[0] = d0s_reg;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        ypcb_div_cell #(.IDX(g)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_vld   (dvv[g]),
            .in_dv    (dvd[g]),
            .in_fwd   (dvf[g]),
            .in_side  (dvs[g]),
            .out_vld  (dvv[g+1]),
            .out_dv   (dvd[g+1]),
            .out_fwd  (dvf[g+1]),
            .out_side (dvs[g+1])
        );
    end

    // ---------------- up vector and row assembly ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= '0;
        end else if (adv) begin
            e_vld_reg <= {e_vld_reg[1:0], dvv[DIV_CELLS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dvd[DIV_CELLS].zero) begin
                rx1_reg <= ONE_Q30;
                rz1_reg <= '0;
            end else begin
                rx1_reg <= dvd[DIV_CELLS].neg_x ? -$signed(36'(dvd[DIV_CELLS].q_x))
                                                : $signed(36'(dvd[DIV_CELLS].q_x));
                rz1_reg <= dvd[DIV_CELLS].neg_z ? -$signed(36'(dvd[DIV_CELLS].q_z))
                                                : $signed(36'(dvd[DIV_CELLS].q_z));
            end
            ef_reg[0]    <= dvf[DIV_CELLS];
            eside_reg[0] <= dvs[DIV_CELLS];

            m1_reg       <= mulq30(ef_reg[0].fy, rz1_reg);
            m2_reg       <= mulq30(ef_reg[0].fz, rx1_reg);
            m3_reg       <= mulq30(ef_reg[0].fx, rz1_reg);
            m4_reg       <= mulq30(ef_reg[0].fy, rx1_reg);
            rx2_reg      <= rx1_reg;
            rz2_reg      <= rz1_reg;
            ef_reg[1]    <= ef_reg[0];
            eside_reg[1] <= eside_reg[0];

            tail_rows_reg[ROW_RIGHT]   <= '{sat32(rx2_reg), 32'sd0, sat32(rz2_reg)};
            tail_rows_reg[ROW_UP]      <= '{sat32(m1_reg), sat32(m2_reg - m3_reg),
                                            sat32(-m4_reg)};
            tail_rows_reg[ROW_FORWARD] <= '{sat32(ef_reg[1].fx), sat32(ef_reg[1].fy),
                                            sat32(ef_reg[1].fz)};
            tail_rows_reg[ROW_POS]     <= '{eside_reg[1].pos_x, eside_reg[1].pos_y,
                                            eside_reg[1].pos_z};
            tail_rows_reg[ROW_FOV]     <= '{$signed(eside_reg[1].fov_rad), 32'sd0, 32'sd0};
            tail_apply_reg             <= eside_reg[1].fov_apply;
        end
    end

    // ---------------- row serializer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_vld_reg <= 1'b0;
            row_reg     <= ROW_RIGHT;
        end else if (adv && tail_vld) begin
            ser_vld_reg <= 1'b1;
            row_reg     <= ROW_RIGHT;
        end else if (ser_vld_reg && m_ready) begin
            if (row_reg == ROW_FOV) begin
                ser_vld_reg <= 1'b0;
                row_reg     <= ROW_RIGHT;
            end else begin
                row_reg     <= row_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tail_vld) begin
            ser_rows_reg  <= tail_rows_reg;
            ser_apply_reg <= tail_apply_reg;
        end
    end

    always_comb begin
        unique case (row_reg)
            ROW_RIGHT:   row_c = ser_rows_reg[0];
            ROW_UP:      row_c = ser_rows_reg[1];
            ROW_FORWARD: row_c = ser_rows_reg[2];
            ROW_POS:     row_c = ser_rows_reg[3];
            ROW_FOV:     row_c = ser_rows_reg[4];
            default:     row_c = '0;
        endcase
    end

    assign m_valid     = ser_vld_reg;
    assign m_row_index = row_reg;
    assign m_comp_x    = row_c.x;
    assign m_comp_y    = row_c.y;
    assign m_comp_z    = row_c.z;
    assign m_fov_apply = (row_reg == ROW_FOV) && ser_apply_reg;
    assign m_last_row  = (row_reg == ROW_FOV);

endmodule

`default_nettype wire

// ===== sim/yaw_pitch_to_camera_basis_top_tb.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_to_camera_basis_top_tb: self-checking bench for the camera basis
// Sends camera poses through a valid/ready channel and compares every row
// beat against a bit-exact predictor: yaw/pitch reduction, CORDIC, basis
// normalization, cross product and fov conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module yaw_pitch_to_camera_basis_top_tb;
    import ypcb_pkg::*;

    localparam int STEPS     = 24;
    localparam int LATENCY   = STEPS + 82;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [2:0]         row;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               apply;
        logic               last;
    } row_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_yaw_deg = '0, s_pitch_deg = '0, s_fov_deg = '0;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_row_index;
    logic signed [31:0] m_comp_x, m_comp_y, m_comp_z;
    logic m_fov_apply, m_last_row;

    row_beat_t pending_rows[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  quiet_mode = 0;

    yaw_pitch_to_camera_basis_top #(.CORDIC_STEPS(STEPS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_yaw_deg(s_yaw_deg), .s_pitch_deg(s_pitch_deg), .s_fov_deg(s_fov_deg),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_row_index(m_row_index), .m_comp_x(m_comp_x), .m_comp_y(m_comp_y),
        .m_comp_z(m_comp_z), .m_fov_apply(m_fov_apply), .m_last_row(m_last_row)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint deg_to_rad(longint v, longint unsigned den);
        longint unsigned q;
        q = (abs64(v) * longint'(PI_Q30) + den / 2) / den;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round_div(longint a, longint b);
        longint unsigned mb, q;
        mb = abs64(b);
        if (mb == 0) return 0;
        q = (abs64(a) + mb / 2) / mb;
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic angle_sincos(input longint deg, output longint c, output longint s);
        longint z, x, y, nx, at;
        z = deg_to_rad(deg, 64'd11796480);
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            at = longint'(ATAN_Q30[i]);
            if (z >= 0) begin
                nx = x - shr_arith(y, i);
                y = y + shr_arith(x, i);
                z -= at;
            end else begin
                nx = x + shr_arith(y, i);
                y = y - shr_arith(x, i);
                z += at;
            end
            x = nx;
        end
        c = x;
        s = y;
    endtask

    task automatic predict_basis(input logic signed [31:0] yaw_in, pitch_in, fov_in,
                                 input logic signed [31:0] px, py, pz);
        longint yaw, pitch, fov, cy, sy, cp, sp, fx, fy, fz, rx, ry, rz;
        longint ux, uy, uz, frad, f, one;
        longint unsigned flat;
        longint comps[5][3];
        bit fold;
        row_beat_t b;
        one = longint'(1) << 30;
        yaw = longint'(yaw_in) % 23592960;
        pitch = pitch_in;
        fov = fov_in;
        fold = 0;
        frad = 0;
        if (yaw < 0) yaw += 23592960;
        if (yaw >= 11796480) yaw -= 23592960;
        if (yaw > 5898240) begin
            yaw -= 11796480;
            fold = 1;
        end else if (yaw < -5898240) begin
            yaw += 11796480;
            fold = 1;
        end
        if (pitch > 5832704) pitch = 5832704;
        if (pitch < -5832704) pitch = -5832704;
        angle_sincos(yaw, cy, sy);
        if (fold) begin
            cy = -cy;
            sy = -sy;
        end
        angle_sincos(pitch, cp, sp);
        fx = q30_mul(sy, cp);
        fy = sp;
        fz = q30_mul(cy, cp);
        flat = floor_sqrt(longint'(fx * fx) + longint'(fz * fz));
        if (flat == 0) begin
            rx = one; ry = 0; rz = 0;
        end else begin
            rx = round_div(fz * one, longint'(flat));
            ry = 0;
            rz = round_div(-fx * one, longint'(flat));
        end
        ux = q30_mul(fy, rz) - q30_mul(fz, ry);
        uy = q30_mul(fz, rx) - q30_mul(fx, rz);
        uz = q30_mul(fx, ry) - q30_mul(fy, rx);
        if (fov > 0) begin
            f = fov < 327680 ? 327680 : (fov > 11141120 ? 11141120 : fov);
            frad = deg_to_rad(f, 64'd11796480 << 2);
        end
        comps = '{'{rx, ry, rz}, '{ux, uy, uz}, '{fx, fy, fz},
                  '{longint'(px), longint'(py), longint'(pz)}, '{frad, 0, 0}};
        for (int k = 0; k < 5; k++) begin
            b.row = 3'(k);
            b.cx = clip32(comps[k][0]);
            b.cy = clip32(comps[k][1]);
            b.cz = clip32(comps[k][2]);
            b.apply = (k == ROW_FOV) && (fov > 0);
            b.last = (k == ROW_FOV);
            pending_rows.push_back(b);
        end
    endtask

    // sender: one pose per call, idles at random unless in quiet mode
    task automatic send_pose(input logic signed [31:0] yaw, pitch, fov, px, py, pz);
        while (!quiet_mode && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_yaw_deg <= yaw; s_pitch_deg <= pitch; s_fov_deg <= fov;
        s_pos_x <= px; s_pos_y <= py; s_pos_z <= pz;
        do @(posedge aclk); while (!s_ready);
        predict_basis(yaw, pitch, fov, px, py, pz);
        @(negedge aclk);
    endtask

    // drop valid at a falling edge
    task automatic stop_input();
        s_valid <= 1'b0;
    endtask

    task automatic drain_rows();
        stop_input();
        wait (pending_rows.size() == 0);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    task automatic test_directed_extremes();
        send_pose(0, 0, 90 <<< 16, 0, 0, 0);
        send_pose(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_pose(32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_pose(-1, -1, -1, -1, -1, -1);
        send_pose(90 <<< 16, 89 <<< 16, 5 <<< 16, 1, 2, 3);
        send_pose((90 <<< 16) + 1, -(89 <<< 16), 4 <<< 16, 0, 0, 0);
        send_pose(-(90 <<< 16) - 1, (89 <<< 16) + 1, 170 <<< 16, 0, 0, 0);
        send_pose(180 <<< 16, -(89 <<< 16) - 1, (170 <<< 16) + 1, 0, 0, 0);
        send_pose(-(180 <<< 16), 45 <<< 16, 1, 0, 0, 0);
        send_pose(360 <<< 16, -(45 <<< 16), 0, 0, 0, 0);
        send_pose(270 <<< 16, 0, 60 <<< 16, 5, -5, 7);
        send_pose(-(270 <<< 16), 0, 60 <<< 16, 0, 0, 0);
        send_pose(-(360 <<< 16), 1, 1 <<< 16, 0, 0, 0);
    endtask

    task automatic test_random_poses(input int count);
        logic signed [31:0] yaw, pitch, fov;
        for (int n = 0; n < count; n++) begin
            yaw = $urandom_range(3) == 0 ? $urandom : $urandom_range(23592960) - 11796480;
            pitch = $urandom_range(3) == 0 ? $urandom : $urandom_range(12582912) - 6291456;
            case ($urandom_range(3))
                0: fov = $urandom;
                1: fov = -$urandom_range(1 << 20);
                default: fov = $urandom_range(12000000);
            endcase
            send_pose(yaw, pitch, fov, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_back_to_back();
        quiet_mode = 1;
        test_random_poses(40);
        quiet_mode = 0;
    endtask

    task automatic test_pause_until_drained();
        test_random_poses(5);
        stop_input();
        wait (pending_rows.size() == 0);
        @(negedge aclk);
        test_random_poses(5);
    endtask

    // ready: random stalls, none in quiet mode
    always @(negedge aclk) begin
        m_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        row_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rows.size() == 0) begin
                $error("row beat with nothing expected: row %0d", m_row_index);
                fail_count++;
            end else begin
                e = pending_rows.pop_front();
                if (m_row_index !== e.row) begin
                    $error("row_index exp %0d got %0d", e.row, m_row_index);
                    fail_count++;
                end
                if (m_comp_x !== e.cx) begin
                    $error("comp_x row %0d exp %0d got %0d", e.row, e.cx, m_comp_x);
                    fail_count++;
                end
                if (m_comp_y !== e.cy) begin
                    $error("comp_y row %0d exp %0d got %0d", e.row, e.cy, m_comp_y);
                    fail_count++;
                end
                if (m_comp_z !== e.cz) begin
                    $error("comp_z row %0d exp %0d got %0d", e.row, e.cz, m_comp_z);
                    fail_count++;
                end
                if (m_fov_apply !== e.apply) begin
                    $error("fov_apply exp %0d got %0d", e.apply, m_fov_apply);
                    fail_count++;
                end
                if (m_last_row !== e.last) begin
                    $error("last_row exp %0d got %0d", e.last, m_last_row);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_extremes();
        test_pause_until_drained();
        test_back_to_back();
        test_random_poses(215);
        drain_rows();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/ypcb_pkg.sv
src/ypcb_cordic_cell.sv
src/ypcb_sqrt_cell.sv
src/ypcb_div_cell.sv
src/yaw_pitch_to_camera_basis_top.sv
sim/yaw_pitch_to_camera_basis_top_tb.sv
